FILE: hw/rtl/cdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int STAT_W  = 2;
  localparam int MLEN_W  = 5;
  localparam int ORD_W   = 9;
  localparam int WDAY_W  = 3;
  localparam int QUOT_W  = 10;

  // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for every 16-bit y;
  // the low RECIP_SHIFT bits of the product stay below RECIP_100 exactly
  // when y is a multiple of 100.
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 20;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

  localparam logic [MLEN_W-1:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [3:0]        WEEK_LEN     = 4'd7;
  localparam logic [WDAY_W-1:0] SUNDAY       = 3'd7;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_YEAR  = 2'd1,
    STATUS_BAD_MONTH = 2'd2,
    STATUS_BAD_DAY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              div100;
  } ydiv_t;

  typedef struct packed {
    status_t           status_code;
    logic              leap_flag;
    logic [MLEN_W-1:0] month_length;
    logic [ORD_W-1:0]  ordinal_day;
    logic [WDAY_W-1:0] iso_weekday;
  } result_t;

  function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ORD_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cdc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cdc_in_if;
  import cdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_number;
  logic [MONTH_W-1:0] month_number;
  logic [DAY_W-1:0]   day_number;

  modport source (output valid, output year_number, output month_number,
                  output day_number, input ready);
  modport sink (input valid, input year_number, input month_number,
                input day_number, output ready);
endinterface

interface cdc_out_if;
  import cdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status_code;
  logic              leap_flag;
  logic [MLEN_W-1:0] month_length;
  logic [ORD_W-1:0]  ordinal_day;
  logic [WDAY_W-1:0] iso_weekday;

  modport source (output valid, output status_code, output leap_flag,
                  output month_length, output ordinal_day, output iso_weekday,
                  input ready);
  modport sink (input valid, input status_code, input leap_flag,
                input month_length, input ordinal_day, input iso_weekday,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cdc_year_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cdc_year_div (
  input  wire logic [cdc_pkg::YEAR_W-1:0] year,
  output cdc_pkg::ydiv_t                  ydiv
);
  import cdc_pkg::*;

  logic [PROD_W-1:0]      prod;
  logic [RECIP_SHIFT-1:0] frac;

  assign prod = {{(PROD_W-YEAR_W){1'b0}}, year} * {{(PROD_W-RECIP_W){1'b0}}, RECIP_100};
  assign frac = prod[RECIP_SHIFT-1:0];

  assign ydiv.quot   = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  // fraction below one reciprocal step means the remainder is zero
  assign ydiv.div100 = (frac < {{(RECIP_SHIFT-RECIP_W){1'b0}}, RECIP_100});

endmodule

`default_nettype wire

FILE: hw/rtl/cdc_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module cdc_eval (
  input  wire logic [cdc_pkg::YEAR_W-1:0]  year,
  input  wire logic [cdc_pkg::MONTH_W-1:0] month,
  input  wire logic [cdc_pkg::DAY_W-1:0]   day,
  output cdc_pkg::result_t                 res
);
  import cdc_pkg::*;

  ydiv_t             ydiv;
  logic              leap;
  logic              month_ok;
  logic              day_ok;
  logic              early;
  logic [MLEN_W-1:0] len;
  logic [YEAR_W-1:0] yw;
  logic [QUOT_W-1:0] qw;
  logic [16:0]       wsum;
  logic [5:0]        dsum;
  logic [3:0]        fold4;
  logic [3:0]        fold;
  logic [2:0]        rem;
  logic [WDAY_W-1:0] wday;
  logic [ORD_W-1:0]  ord;

  cdc_year_div u_div (
    .year (year),
    .ydiv (ydiv)
  );

  assign leap = ((year[1:0] == 2'd0) && !ydiv.div100) ||
                (ydiv.div100 && (ydiv.quot[1:0] == 2'd0));

  assign month_ok = (month != '0) && (month <= MONTH_DEC);
  assign len      = (month == MONTH_FEB && leap) ? FEB_LEAP_LEN : month_days(month);
  assign day_ok   = (day != '0) && (day <= len);

  // January and February count in the previous year
  assign early = (month < MONTH_MAR);
  assign yw    = early ? year - 16'd1 : year;
  assign qw    = (early && ydiv.div100) ? ydiv.quot - 10'd1 : ydiv.quot;

  assign wsum = {1'b0, yw} + {3'b0, yw[YEAR_W-1:2]} - {7'b0, qw}
              + {9'b0, qw[QUOT_W-1:2]} + {14'b0, month_shift(month)} + {12'b0, day};

  // 8 = 1 mod 7: sum the octal digits, then fold twice
  assign dsum  = {3'b0, wsum[2:0]} + {3'b0, wsum[5:3]} + {3'b0, wsum[8:6]}
               + {3'b0, wsum[11:9]} + {3'b0, wsum[14:12]} + {4'b0, wsum[16:15]};
  assign fold4 = {1'b0, dsum[2:0]} + {1'b0, dsum[5:3]};
  assign fold  = {1'b0, fold4[2:0]} + {3'b0, fold4[3]};
  assign rem   = (fold >= WEEK_LEN) ? 3'(fold - WEEK_LEN) : fold[2:0];
  assign wday  = (rem == 3'd0) ? SUNDAY : rem;

  assign ord = month_start(month) + {4'b0, day} + {8'b0, (leap && month > MONTH_FEB)};

  always_comb begin
    res.leap_flag    = leap;
    res.status_code  = STATUS_OK;
    res.month_length = '0;
    res.ordinal_day  = '0;
    res.iso_weekday  = '0;
    if (year == '0) begin
      res.status_code = STATUS_BAD_YEAR;
    end else if (!month_ok) begin
      res.status_code = STATUS_BAD_MONTH;
    end else if (!day_ok) begin
      res.status_code = STATUS_BAD_DAY;
    end else begin
      res.month_length = len;
      res.ordinal_day  = ord;
      res.iso_weekday  = wday;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_date_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date checker. Each word on req is one date (year, month, day);
// each word on rsp is its status, leap flag, month length, day of year and
// ISO weekday (1 Monday .. 7 Sunday), with the last three zero on any error.
// One date is taken per cycle, sustained while rsp is ready; its result word
// goes through the input register, then the result register, and is held on
// rsp until taken there. The whole evaluation sits in one stage between those
// registers, built around a single 16 x 20 reciprocal multiply that yields
// year / 100 and the divisible-by-100 test.
// Back-pressure on rsp holds the result register, and holds req once the
// input register is full as well.
module calendar_date_checker (
  input  wire logic clk,
  input  wire logic rst,
  cdc_in_if.sink    req,
  cdc_out_if.source rsp
);
  import cdc_pkg::*;

  logic               s1_valid;
  logic [YEAR_W-1:0]  s1_year;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic               s2_valid;
  result_t            s2_res;
  result_t            eval_res;
  logic               s1_adv;
  logic               s2_adv;
  logic               s2_load;

  assign s2_adv  = !s2_valid || rsp.ready;
  assign s1_adv  = !s1_valid || s2_adv;
  assign s2_load = s1_valid && s2_adv;

  assign req.ready = s1_adv;

  cdc_eval u_eval (
    .year  (s1_year),
    .month (s1_month),
    .day   (s1_day),
    .res   (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= req.valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && req.valid) begin
      s1_year  <= req.year_number;
      s1_month <= req.month_number;
      s1_day   <= req.day_number;
    end
    if (s2_load) begin
      s2_res <= eval_res;
    end
  end

  assign rsp.valid        = s2_valid;
  assign rsp.status_code  = s2_res.status_code;
  assign rsp.leap_flag    = s2_res.leap_flag;
  assign rsp.month_length = s2_res.month_length;
  assign rsp.ordinal_day  = s2_res.ordinal_day;
  assign rsp.iso_weekday  = s2_res.iso_weekday;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status_code != STATUS_OK) |->
      (rsp.month_length == '0 && rsp.ordinal_day == '0 && rsp.iso_weekday == '0))
    else $error("error word carries nonzero date fields");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status_code == STATUS_OK) |->
      (rsp.iso_weekday != '0 && rsp.ordinal_day != '0 && rsp.month_length >= 5'd28))
    else $error("valid date word has empty fields");

  a_feb29_leap: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.month_length == FEB_LEAP_LEN) |-> rsp.leap_flag)
    else $error("29-day month without leap flag");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> s2_valid)
    else $error("word lost between stages");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cdc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_DATES  = 800;
  localparam int QUIET_TAIL    = 150;
  localparam int DRAIN_AT      = 400;
  localparam int DIRECTED_ROWS = 24;

  localparam int MONTH_LEN [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               typed;
    result_t            answer;
  } date_row_t;

  localparam result_t NO_ANSWER = '0;

  // Rows with typed = 1 carry their answer; the rest go through predict_date.
  localparam date_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'd0,     4'd1,  5'd1,  1'b1, '{STATUS_BAD_YEAR,  1'b1, 5'd0,  9'd0, 3'd0}},
    '{16'd0,     4'd0,  5'd0,  1'b1, '{STATUS_BAD_YEAR,  1'b1, 5'd0,  9'd0, 3'd0}},
    '{16'd2023,  4'd0,  5'd15, 1'b1, '{STATUS_BAD_MONTH, 1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd2024,  4'd13, 5'd1,  1'b1, '{STATUS_BAD_MONTH, 1'b1, 5'd0,  9'd0, 3'd0}},
    '{16'd1,     4'd15, 5'd31, 1'b1, '{STATUS_BAD_MONTH, 1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd2023,  4'd2,  5'd29, 1'b1, '{STATUS_BAD_DAY,   1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd2024,  4'd2,  5'd30, 1'b1, '{STATUS_BAD_DAY,   1'b1, 5'd0,  9'd0, 3'd0}},
    '{16'd2023,  4'd4,  5'd31, 1'b1, '{STATUS_BAD_DAY,   1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd2023,  4'd1,  5'd0,  1'b1, '{STATUS_BAD_DAY,   1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd1900,  4'd2,  5'd29, 1'b1, '{STATUS_BAD_DAY,   1'b0, 5'd0,  9'd0, 3'd0}},
    '{16'd1,     4'd1,  5'd1,  1'b1, '{STATUS_OK,        1'b0, 5'd31, 9'd1, 3'd1}},
    '{16'd65535, 4'd12, 5'd31, 1'b0, NO_ANSWER},
    '{16'd65535, 4'd2,  5'd28, 1'b0, NO_ANSWER},
    '{16'd2024,  4'd2,  5'd29, 1'b0, NO_ANSWER},
    '{16'd2000,  4'd2,  5'd29, 1'b0, NO_ANSWER},
    '{16'd2000,  4'd12, 5'd31, 1'b0, NO_ANSWER},
    '{16'd1900,  4'd3,  5'd1,  1'b0, NO_ANSWER},
    '{16'd2024,  4'd1,  5'd1,  1'b0, NO_ANSWER},
    '{16'd2023,  4'd5,  5'd31, 1'b0, NO_ANSWER},
    '{16'd2023,  4'd6,  5'd30, 1'b0, NO_ANSWER},
    '{16'd2023,  4'd7,  5'd31, 1'b0, NO_ANSWER},
    '{16'd2023,  4'd8,  5'd31, 1'b0, NO_ANSWER},
    '{16'd2023,  4'd9,  5'd30, 1'b0, NO_ANSWER},
    '{16'd2023,  4'd11, 5'd30, 1'b0, NO_ANSWER}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdc_in_if  req_if ();
  cdc_out_if rsp_if ();

  calendar_date_checker u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  result_t     pending_results[$];
  int          idle_pct     = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic leap_year(input logic [YEAR_W-1:0] year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  function automatic int month_len(input logic [MONTH_W-1:0] month, input logic leap);
    if (month == MONTH_FEB && leap) return 29;
    return MONTH_LEN[month - 1];
  endfunction

  function automatic result_t predict_date(input logic [YEAR_W-1:0] year,
                                           input logic [MONTH_W-1:0] month,
                                           input logic [DAY_W-1:0] day);
    result_t     r;
    logic        leap;
    int          len;
    int unsigned y;
    int unsigned sum;
    r = '0;
    leap = leap_year(year);
    r.leap_flag = leap;
    r.status_code = STATUS_OK;
    if (year == 0) begin
      r.status_code = STATUS_BAD_YEAR;
    end else if (month == 0 || month > MONTH_DEC) begin
      r.status_code = STATUS_BAD_MONTH;
    end else begin
      len = month_len(month, leap);
      if (day == 0 || day > len) begin
        r.status_code = STATUS_BAD_DAY;
      end else begin
        r.month_length = MLEN_W'(len);
        r.ordinal_day = ORD_W'(MONTH_START[month - 1] + day
                               + ((leap && month > MONTH_FEB) ? 1 : 0));
        // January and February belong to the previous year here
        y = year;
        if (month < MONTH_MAR) y = y - 1;
        sum = (y + y / 4 - y / 100 + y / 400 + MONTH_SHIFT[month - 1] + day) % 7;
        r.iso_weekday = (sum == 0) ? SUNDAY : WDAY_W'(sum);
      end
    end
    return r;
  endfunction

  task automatic send_date(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month,
                           input logic [DAY_W-1:0] day, input logic typed,
                           input result_t answer);
    req_if.valid        <= 1'b1;
    req_if.year_number  <= year;
    req_if.month_number <= month;
    req_if.day_number   <= day;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(typed ? answer : predict_date(year, month, day));
  endtask

  task automatic maybe_pause();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
      fail_count++;
    end
  endtask

  // Result side: compare each word with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      status_seen[rsp_if.status_code]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got status %0d ordinal %0d",
                 $time, rsp_if.status_code, rsp_if.ordinal_day);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status_code", want.status_code, rsp_if.status_code);
        check_field("leap_flag", want.leap_flag, rsp_if.leap_flag);
        check_field("month_length", want.month_length, rsp_if.month_length);
        check_field("ordinal_day", want.ordinal_day, rsp_if.ordinal_day);
        check_field("iso_weekday", want.iso_weekday, rsp_if.iso_weekday);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result ready: random stall bursts, none while idle_pct is zero.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    int                 len;
    int                 pick;
    req_if.valid        <= 1'b0;
    req_if.year_number  <= '0;
    req_if.month_number <= '0;
    req_if.day_number   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_date(DIRECTED[i].year, DIRECTED[i].month, DIRECTED[i].day,
                DIRECTED[i].typed, DIRECTED[i].answer);
      maybe_pause();
    end

    for (int i = 0; i < RANDOM_DATES; i++) begin
      if (i >= RANDOM_DATES - QUIET_TAIL) idle_pct = 0;
      else idle_pct = (i / 100 % 3 == 0) ? 0 : (i / 100 % 3 == 1) ? 15 : 40;

      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: year = YEAR_W'($urandom_range(1, 65535));
        3, 4:    year = YEAR_W'($urandom_range(1, 2100));
        5:       year = YEAR_W'($urandom_range(1, 655) * 100);
        6:       year = YEAR_W'($urandom_range(1, 163) * 400);
        default: year = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
      endcase
      month = MONTH_W'($urandom_range(1, 12));
      len = month_len(month, leap_year(year));
      day = DAY_W'($urandom_range(1, len));

      // Mostly well-formed dates; the rest is noise and near misses.
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        year = ($urandom_range(0, 7) == 0) ? 16'd0 : YEAR_W'($urandom_range(0, 65535));
        month = MONTH_W'($urandom_range(0, 15));
        day = DAY_W'($urandom_range(0, 31));
      end else if (pick == 8) begin
        day = (len == 31 || $urandom_range(0, 3) == 0) ? 5'd0
            : DAY_W'($urandom_range(len + 1, 31));
      end else if (pick == 9) begin
        month = $urandom_range(0, 1) ? 4'd0 : MONTH_W'($urandom_range(13, 15));
      end

      send_date(year, month, day, 1'b0, NO_ANSWER);
      if (i == DRAIN_AT) begin
        // hold the sender until every result is back
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end else begin
        maybe_pause();
      end
    end

    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);

    $display("Checked %0d dates from directed extremes and random years 0..65535:",
             status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]);
    $display("  %0d valid, %0d bad year, %0d bad month, %0d bad day, with stall bursts",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
